/* hw/rtl/lbsp_pkg.sv */
package lbsp_pkg;

   localparam int MAX_MAGIC_BYTES_DEF = 8;

   typedef enum logic [3:0] {
      EV_BLOCK_START   = 4'd0,
      EV_HEADER_KEY    = 4'd1,
      EV_HEADER_BYTE   = 4'd2,
      EV_CONTENT_START = 4'd3,
      EV_CONTENT_BYTE  = 4'd4,
      EV_FOOTER_KEY    = 4'd5,
      EV_FOOTER_BYTE   = 4'd6,
      EV_BLOCK_END     = 4'd7,
      EV_CLEAN_END     = 4'd8,
      EV_ERROR         = 4'd9
   } event_type;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_MAGIC     = 3'd1;
   localparam logic [2:0] ERR_VERSION   = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_LENGTH    = 3'd4;

   localparam logic [1:0] CSR_MAGIC_PATTERN = 2'd0;
   localparam logic [1:0] CSR_MAGIC_LENGTH  = 2'd1;
   localparam logic [1:0] CSR_VERSION       = 2'd2;

   // one result item
   typedef struct packed {
      event_type   ev;
      logic [31:0] number;
      logic [63:0] length;
      logic [7:0]  payload;
      logic [2:0]  error_code;
      logic        last;
   } result_type;

   // up to two results per input byte
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } bundle_type;

endpackage

/* hw/rtl/lbsp_front.sv */
module lbsp_front
   import lbsp_pkg::*;
#(
   parameter int MAX_MAGIC_BYTES = MAX_MAGIC_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [63:0] csr_wdata,
   input  logic       in_valid,
   input  logic [7:0] in_byte,
   input  logic       in_final,
   output logic       out_valid,
   output bundle_type out_bundle
);

   typedef enum logic [9:0] {
      PH_MAGIC   = 10'b0000000001,
      PH_BLEN    = 10'b0000000010,
      PH_VER     = 10'b0000000100,
      PH_TYPE    = 10'b0000001000,
      PH_COUNT   = 10'b0000010000,
      PH_ENTRY   = 10'b0000100000,
      PH_VALUE   = 10'b0001000000,
      PH_CLEN    = 10'b0010000000,
      PH_CONTENT = 10'b0100000000,
      PH_TRAIL   = 10'b1000000000
   } phase_type;

   localparam logic [3:0] MAXM = 4'(MAX_MAGIC_BYTES);

   logic [63:0] magic_pattern_ff;
   logic [3:0]  magic_length_ff;
   logic [31:0] version_ff;

   phase_type   phase_ff, phase_in;
   logic [3:0]  fcnt_ff, fcnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] dlen_ff, dlen_in;
   logic [63:0] bcnt_ff, bcnt_in;
   logic [31:0] entries_ff, entries_in;
   logic [63:0] left_ff, left_in;
   logic        mism_ff, mism_in;
   logic        footer_ff, footer_in;
   logic        err_ff, err_in;

   logic [1:0]  n_res;
   result_type  r0, r1;
   bundle_type  bundle_in;
   logic [3:0]  mlen, midx, fw, sidx;
   logic [5:0]  shamt;
   logic [63:0] acc_sh;
   logic [2:0]  err;
   logic        boundary, handled;
   logic        bsat;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_pattern_ff <= 64'h0000_2348_5544_4923;
         magic_length_ff  <= 4'd6;
         version_ff       <= 32'd1;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAGIC_PATTERN: magic_pattern_ff <= csr_wdata;
            CSR_MAGIC_LENGTH:  magic_length_ff  <= csr_wdata[3:0];
            CSR_VERSION:       version_ff       <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_MAGIC;
         fcnt_ff    <= '0;
         acc_ff     <= '0;
         dlen_ff    <= '0;
         bcnt_ff    <= '0;
         entries_ff <= '0;
         left_ff    <= '0;
         mism_ff    <= 1'b0;
         footer_ff  <= 1'b0;
         err_ff     <= 1'b0;
         out_valid  <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         fcnt_ff    <= fcnt_in;
         acc_ff     <= acc_in;
         dlen_ff    <= dlen_in;
         bcnt_ff    <= bcnt_in;
         entries_ff <= entries_in;
         left_ff    <= left_in;
         mism_ff    <= mism_in;
         footer_ff  <= footer_in;
         err_ff     <= err_in;
         out_valid  <= n_res != 2'd0;
      end
   end

   function automatic result_type mk(event_type e, logic [31:0] num, logic [63:0] len,
                                     logic [7:0] pay, logic [2:0] ec);
      result_type r;
      r.ev = e; r.number = num; r.length = len; r.payload = pay;
      r.error_code = ec; r.last = 1'b0;
      return r;
   endfunction

   always_comb begin
      phase_in = phase_ff; fcnt_in = fcnt_ff; acc_in = acc_ff; dlen_in = dlen_ff;
      bcnt_in = bcnt_ff; entries_in = entries_ff; left_in = left_ff;
      mism_in = mism_ff; footer_in = footer_ff; err_in = err_ff;
      n_res = 2'd0; r0 = '0; r1 = '0;
      err = ERR_NONE; boundary = 1'b0; handled = 1'b0;
      bsat = bcnt_ff == '1;
      mlen = magic_length_ff;
      if (mlen < 4'd1) mlen = 4'd1;
      if (mlen > MAXM) mlen = MAXM;
      midx = (fcnt_ff >= mlen) ? mlen - 4'd1 : fcnt_ff;
      sidx = mlen - 4'd1 - midx;
      shamt = {sidx[2:0], 3'b000};
      acc_sh = {acc_ff[55:0], in_byte};
      fw = (phase_ff == PH_BLEN || phase_ff == PH_ENTRY || phase_ff == PH_CLEN ||
            phase_ff == PH_TRAIL) ? 4'd8 : 4'd4;
      if (in_valid && !err_ff) begin
         unique case (phase_ff)
            PH_MAGIC: begin
               if (magic_pattern_ff[shamt +: 8] != in_byte) mism_in = 1'b1;
               fcnt_in = midx + 4'd1;
               if (fcnt_in >= mlen) begin
                  if (mism_in) err = ERR_MAGIC;
                  else begin
                     phase_in = PH_BLEN; fcnt_in = '0; acc_in = '0; mism_in = 1'b0;
                  end
               end else if (in_final) begin
                  r0 = mk(EV_CLEAN_END, '0, '0, '0, ERR_NONE); n_res = 2'd1;
                  fcnt_in = '0; acc_in = '0; mism_in = 1'b0; handled = 1'b1;
               end
            end
            PH_VALUE, PH_CONTENT: begin
               if (!bsat) bcnt_in = bcnt_ff + 64'd1;
               left_in = left_ff - 64'd1;
               n_res = 2'd1;
               if (phase_ff == PH_VALUE) begin
                  r0 = mk(footer_ff ? EV_FOOTER_BYTE : EV_HEADER_BYTE, '0, '0, in_byte,
                          ERR_NONE);
                  if (left_in == '0) begin
                     entries_in = entries_ff - 32'd1;
                     fcnt_in = '0; acc_in = '0;
                     phase_in = (entries_in == '0) ? (footer_ff ? PH_TRAIL : PH_CLEN)
                                                   : PH_ENTRY;
                  end
               end else begin
                  r0 = mk(EV_CONTENT_BYTE, '0, '0, in_byte, ERR_NONE);
                  if (left_in == '0) begin
                     footer_in = 1'b1; phase_in = PH_COUNT; fcnt_in = '0; acc_in = '0;
                  end
               end
            end
            default: begin
               if (phase_ff != PH_BLEN && !bsat) bcnt_in = bcnt_ff + 64'd1;
               acc_in = acc_sh;
               fcnt_in = fcnt_ff + 4'd1;
               if (fcnt_in >= fw) begin
                  fcnt_in = '0; acc_in = '0;
                  priority case (1'b1)
                     phase_ff == PH_BLEN: begin
                        dlen_in = acc_sh; bcnt_in = '0; phase_in = PH_VER;
                     end
                     phase_ff == PH_VER: begin
                        if (acc_sh[31:0] != version_ff) err = ERR_VERSION;
                        else phase_in = PH_TYPE;
                     end
                     phase_ff == PH_TYPE: begin
                        r0 = mk(EV_BLOCK_START, acc_sh[31:0], '0, '0, ERR_NONE);
                        n_res = 2'd1; footer_in = 1'b0; phase_in = PH_COUNT;
                     end
                     phase_ff == PH_COUNT: begin
                        entries_in = acc_sh[31:0];
                        phase_in = (acc_sh[31:0] == '0) ? (footer_ff ? PH_TRAIL : PH_CLEN)
                                                        : PH_ENTRY;
                     end
                     phase_ff == PH_ENTRY: begin
                        r0 = mk(footer_ff ? EV_FOOTER_KEY : EV_HEADER_KEY, acc_sh[63:32],
                                {32'd0, acc_sh[31:0]}, '0, ERR_NONE);
                        n_res = 2'd1;
                        if (acc_sh[31:0] == '0) begin
                           entries_in = entries_ff - 32'd1;
                           phase_in = (entries_in == '0) ?
                                      (footer_ff ? PH_TRAIL : PH_CLEN) : PH_ENTRY;
                        end else begin
                           left_in = {32'd0, acc_sh[31:0]}; phase_in = PH_VALUE;
                        end
                     end
                     phase_ff == PH_CLEN: begin
                        r0 = mk(EV_CONTENT_START, '0, acc_sh, '0, ERR_NONE);
                        n_res = 2'd1;
                        if (acc_sh == '0) begin
                           footer_in = 1'b1; phase_in = PH_COUNT;
                        end else begin
                           left_in = acc_sh; phase_in = PH_CONTENT;
                        end
                     end
                     default: begin
                        if (bcnt_in == dlen_ff) begin
                           r0 = mk(EV_BLOCK_END, '0, '0, '0, ERR_NONE);
                           n_res = 2'd1; boundary = 1'b1;
                           phase_in = PH_MAGIC; mism_in = 1'b0;
                        end else begin
                           err = ERR_LENGTH;
                           fcnt_in = fcnt_ff + 4'd1; acc_in = acc_sh;
                        end
                     end
                  endcase
               end
            end
         endcase
         if (err == ERR_NONE && in_final && !handled) begin
            if (boundary) begin
               r1 = mk(EV_CLEAN_END, '0, '0, '0, ERR_NONE); n_res = 2'd2;
            end else err = ERR_TRUNCATED;
         end
         if (err != ERR_NONE) begin
            err_in = 1'b1;
            if (n_res == 2'd0) begin
               r0 = mk(EV_ERROR, '0, '0, '0, err); n_res = 2'd1;
            end else begin
               r1 = mk(EV_ERROR, '0, '0, '0, err); n_res = 2'd2;
            end
         end
         if (n_res == 2'd1) r0.last = 1'b1;
         if (n_res == 2'd2) r1.last = 1'b1;
      end
      bundle_in.two = n_res == 2'd2;
      bundle_in.r0 = r0;
      bundle_in.r1 = r1;
   end

   always_ff @(posedge clock) begin
      out_bundle <= bundle_in;
   end

endmodule

/* hw/rtl/lbsp_back.sv */
module lbsp_back
   import lbsp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  bundle_type in_bundle,
   output logic       space_ok,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_item
);

   // four-entry result queue; front takes a byte only while queued plus in-flight
   // results leave room for another pair
   logic [1:0] wp_ff, rp_ff;
   logic [2:0] cnt_ff;
   result_type mem_ff [4];
   logic       pop;
   logic [2:0] push_n;

   assign pop = rsp_tvalid && rsp_tready;
   assign push_n = in_valid ? (in_bundle.two ? 3'd2 : 3'd1) : 3'd0;
   assign rsp_tvalid = cnt_ff != 3'd0;
   assign rsp_item = mem_ff[rp_ff];
   // queued results plus the pair possibly in the front register
   assign space_ok = (cnt_ff + push_n) <= 3'd2;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0; rp_ff <= '0; cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_ff + push_n[1:0];
         rp_ff  <= rp_ff + {1'b0, pop};
         cnt_ff <= cnt_ff + push_n - {2'b00, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         mem_ff[wp_ff] <= in_bundle.r0;
         if (in_bundle.two) mem_ff[wp_ff + 2'd1] <= in_bundle.r1;
      end
   end

endmodule

/* hw/rtl/log_block_stream_parser_top.sv */
// path: a req transaction's first result is registered in the front output register,
//   then in the result queue, before its rsp transaction
// throughput: one byte per cycle while results drain one per cycle; a byte that
//   yields two results takes an extra result transaction of output bandwidth; req_tready drops
//   while queued results plus those in the front register exceed two
// reset: synchronous, active high; clears parser state, queue and the sticky
//   error and restores the default six-byte marker and version 1
module log_block_stream_parser_top
   import lbsp_pkg::*;
#(
   parameter int MAX_MAGIC_BYTES = MAX_MAGIC_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [111:0] rsp_tdata,  // number, length, payload_byte, error_code,
                                    // zero fill
   output logic [3:0]  rsp_tuser,   // event_res
   output logic        rsp_tlast    // last_of_run
);

   bundle_type bundle;
   logic       bundle_valid;
   logic       space_ok;
   result_type item;

   // front accepts a byte only when the queue can absorb a worst-case pair
   assign req_tready = space_ok;

   lbsp_front #(.MAX_MAGIC_BYTES(MAX_MAGIC_BYTES)) u_front (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_valid(req_tvalid && req_tready), .in_byte(req_tdata), .in_final(req_tlast),
      .out_valid(bundle_valid), .out_bundle(bundle)
   );

   lbsp_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(bundle_valid), .in_bundle(bundle), .space_ok(space_ok),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_item(item)
   );

   assign rsp_tdata = {5'd0, item.error_code, item.payload, item.length, item.number};
   assign rsp_tuser = item.ev;
   assign rsp_tlast = item.last;

endmodule

/* hw/rtl/lbsp_checker.sv */
module lbsp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [111:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_event_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= 4'd9)
      else $error("bad event code");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == 4'd9 |-> rsp_tlast)
      else $error("error not last of run");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind log_block_stream_parser_top lbsp_checker u_chk (
   .clock(clock), .reset(reset),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
);

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;
   import lbsp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int ITEM_TARGET = 1150;
   localparam int MAX_GAP     = 18;

   // parser position within a block
   typedef enum logic [3:0] {
      PH_MAGIC, PH_BLEN, PH_VER, PH_TYPE, PH_COUNT,
      PH_ENTRY, PH_VALUE, PH_CLEN, PH_CONTENT, PH_TRAIL
   } parse_phase;

   // how the closing block of the run is broken
   typedef enum int {
      F_NONE, F_MAGIC, F_VERSION, F_LENGTH, F_TRUNC
   } fault_kind;

   // predicts parser events and holds the ones still owed by the block
   class event_scoreboard;
      bit [63:0]  pattern;
      bit [3:0]   mlen;
      bit [31:0]  version;
      parse_phase phase;
      bit [3:0]   fcount;
      bit [63:0]  acc, declared, counted, bytes_left;
      bit [31:0]  entries_left;
      bit         mism, footer, stuck;
      result_type pending_q[$];
      result_type run_q[$];
      int         fails;

      function new();
         pattern = 64'h0000_2348_5544_4923;
         mlen = 4'd6;
         version = 32'd1;
         begin_field(PH_MAGIC);
         declared = '0;
         counted = '0;
         bytes_left = '0;
         entries_left = '0;
         mism = 1'b0;
         footer = 1'b0;
         stuck = 1'b0;
         fails = 0;
      endfunction

      function void write_reg(bit [1:0] idx, bit [63:0] v);
         if (idx == CSR_MAGIC_PATTERN) pattern = v;
         else if (idx == CSR_MAGIC_LENGTH) mlen = v[3:0];
         else if (idx == CSR_VERSION) version = v[31:0];
      endfunction

      function int marker_len();
         if (mlen < 1) return 1;
         if (mlen > 8) return 8;
         return mlen;
      endfunction

      function void begin_field(parse_phase p);
         phase = p;
         fcount = '0;
         acc = '0;
      endfunction

      function void map_done();
         begin_field(footer ? PH_TRAIL : PH_CLEN);
      endfunction

      function void entry_done();
         entries_left--;
         if (entries_left == 0) map_done();
         else begin_field(PH_ENTRY);
      endfunction

      function void enter_footer();
         footer = 1'b1;
         begin_field(PH_COUNT);
      endfunction

      function void emit(event_type ev, bit [31:0] num, bit [63:0] len, bit [7:0] pay,
                         bit [2:0] err);
         result_type r;
         r.ev = ev;
         r.number = num;
         r.length = len;
         r.payload = pay;
         r.error_code = err;
         r.last = 1'b0;
         run_q.insert(run_q.size(), r);
      endfunction

      function void bump();
         if (counted != '1) counted++;
      endfunction

      // one accepted byte transaction
      function void note_byte(bit [7:0] b, bit fin);
         int unsigned len, idx, fw;
         bit [2:0] err;
         bit boundary, handled;
         err = ERR_NONE;
         boundary = 1'b0;
         handled = 1'b0;
         run_q.delete();
         if (stuck) return;
         if (phase == PH_MAGIC) begin
            len = marker_len();
            idx = fcount;
            if (idx >= len) idx = len - 1;
            if (8'(pattern >> (8 * (len - 1 - idx))) != b) mism = 1'b1;
            fcount = 4'(idx + 1);
            if (fcount >= len) begin
               if (mism) err = ERR_MAGIC;
               else begin
                  begin_field(PH_BLEN);
                  mism = 1'b0;
               end
            end else if (fin) begin
               emit(EV_CLEAN_END, '0, '0, '0, ERR_NONE);
               begin_field(PH_MAGIC);
               mism = 1'b0;
               handled = 1'b1;
            end
         end else if (phase == PH_VALUE || phase == PH_CONTENT) begin
            bump();
            emit(phase == PH_CONTENT ? EV_CONTENT_BYTE :
                 (footer ? EV_FOOTER_BYTE : EV_HEADER_BYTE), '0, '0, b, ERR_NONE);
            bytes_left--;
            if (bytes_left == 0) begin
               if (phase == PH_VALUE) entry_done();
               else enter_footer();
            end
         end else begin
            if (phase != PH_BLEN) bump();
            acc = {acc[55:0], b};
            fcount++;
            fw = (phase == PH_BLEN || phase == PH_ENTRY || phase == PH_CLEN ||
                  phase == PH_TRAIL) ? 8 : 4;
            if (fcount >= fw) begin
               case (phase)
                  PH_BLEN: begin
                     declared = acc;
                     counted = '0;
                     begin_field(PH_VER);
                  end
                  PH_VER: begin
                     if (acc[31:0] != version) err = ERR_VERSION;
                     else begin_field(PH_TYPE);
                  end
                  PH_TYPE: begin
                     emit(EV_BLOCK_START, acc[31:0], '0, '0, ERR_NONE);
                     footer = 1'b0;
                     begin_field(PH_COUNT);
                  end
                  PH_COUNT: begin
                     entries_left = acc[31:0];
                     if (entries_left == 0) map_done();
                     else begin_field(PH_ENTRY);
                  end
                  PH_ENTRY: begin
                     emit(footer ? EV_FOOTER_KEY : EV_HEADER_KEY, acc[63:32],
                          {32'd0, acc[31:0]}, '0, ERR_NONE);
                     if (acc[31:0] == 0) entry_done();
                     else begin
                        bytes_left = {32'd0, acc[31:0]};
                        phase = PH_VALUE;
                     end
                  end
                  PH_CLEN: begin
                     emit(EV_CONTENT_START, '0, acc, '0, ERR_NONE);
                     if (acc == 0) enter_footer();
                     else begin
                        bytes_left = acc;
                        phase = PH_CONTENT;
                     end
                  end
                  default: begin
                     if (counted == declared) begin
                        emit(EV_BLOCK_END, '0, '0, '0, ERR_NONE);
                        boundary = 1'b1;
                        begin_field(PH_MAGIC);
                        mism = 1'b0;
                     end else err = ERR_LENGTH;
                  end
               endcase
            end
         end
         if (err == ERR_NONE && fin && !handled) begin
            if (boundary) emit(EV_CLEAN_END, '0, '0, '0, ERR_NONE);
            else err = ERR_TRUNCATED;
         end
         if (err != ERR_NONE) begin
            emit(EV_ERROR, '0, '0, '0, err);
            stuck = 1'b1;
         end
         if (run_q.size() > 0) run_q[run_q.size() - 1].last = 1'b1;
         foreach (run_q[i]) pending_q.insert(pending_q.size(), run_q[i]);
      endfunction

      task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
         $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
         fails++;
      endtask

      // one accepted result transaction
      task check_result(logic [111:0] d, logic [3:0] u, logic l);
         result_type e;
         if (pending_q.size() == 0) begin
            report_mismatch("unexpected event", u, '0);
            return;
         end
         e = pending_q.pop_front();
         if (u !== e.ev) report_mismatch("event", u, e.ev);
         if (d[31:0] !== e.number) report_mismatch("number", d[31:0], e.number);
         if (d[95:32] !== e.length) report_mismatch("length", d[95:32], e.length);
         if (d[103:96] !== e.payload) report_mismatch("payload", d[103:96], e.payload);
         if (d[106:104] !== e.error_code)
            report_mismatch("error code", d[106:104], e.error_code);
         if (l !== e.last) report_mismatch("last of run", l, e.last);
      endtask
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         csr_wr_en = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [63:0]  csr_wdata = '0;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata = '0;   // data_byte
   logic         req_tlast = 1'b0; // final_byte
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;        // number, length, payload_byte, error_code
   logic [3:0]   rsp_tuser;        // event_res
   logic         rsp_tlast;        // last_of_run

   event_scoreboard sb = new();
   int  cycles = 0;
   int  bytes_sent = 0;
   bit  send_gaps = 1'b0;
   bit  recv_stalls = 1'b0;
   logic [7:0] file_q[$];

   log_block_stream_parser_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // hard stop in case the block hangs
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // outputs are stable at the falling edge; a transaction there completes at the next rise
   always @(negedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_result(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // result side: random stall before each transaction, none while stalls are off
   initial begin
      int n;
      forever begin
         n = recv_stalls ? $urandom_range(0, MAX_GAP) : 0;
         if (n > 0) begin
            rsp_tready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         forever begin
            @(negedge clock);
            if (rsp_tvalid) break;
         end
         @(posedge clock);
      end
   end

   // drive one byte and wait for its transaction
   task send_byte(logic [7:0] b, logic fin);
      int n;
      n = send_gaps ? $urandom_range(0, MAX_GAP) : 0;
      if (n > 0) begin
         req_tvalid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= fin;
      forever begin
         @(negedge clock);
         if (req_tready) break;
      end
      @(posedge clock);
      sb.note_byte(b, fin);
      bytes_sent++;
   endtask

   // stop sending until every owed event is out, then let the pipe settle
   task drain();
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() > 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task write_csr(logic [1:0] idx, logic [63:0] v);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.write_reg(idx, v);
      @(posedge clock);
   endtask

   task push_be(logic [63:0] v, int nbytes, ref logic [7:0] q[$]);
      for (int i = nbytes - 1; i >= 0; i--) q.insert(q.size(), v[8 * i +: 8]);
   endtask

   task push_map(ref logic [7:0] q[$]);
      int cnt, vl;
      cnt = $urandom_range(0, 3);
      push_be(cnt, 4, q);
      for (int i = 0; i < cnt; i++) begin
         vl = $urandom_range(0, 4);
         push_be($urandom, 4, q);
         push_be(vl, 4, q);
         repeat (vl) q.insert(q.size(), 8'($urandom_range(0, 255)));
      end
   endtask

   // append one block to file_q, broken as asked
   task add_block(fault_kind fault);
      logic [7:0] body[$];
      logic [63:0] blen;
      int len, base, cl;
      len = sb.marker_len();
      base = file_q.size();
      push_be(sb.pattern, len, file_q);
      if (fault == F_MAGIC)
         file_q[base + $urandom_range(0, len - 1)] ^= 8'(1 << $urandom_range(0, 7));
      push_be(fault == F_VERSION ? sb.version ^ $urandom_range(1, 32'hffff_ffff) :
              sb.version, 4, body);
      push_be($urandom, 4, body);
      push_map(body);
      cl = $urandom_range(0, 6);
      push_be(cl, 8, body);
      repeat (cl) body.insert(body.size(), 8'($urandom_range(0, 255)));
      push_map(body);
      push_be({$urandom, $urandom}, 8, body);
      blen = body.size();
      if (fault == F_LENGTH) blen = $urandom_range(0, 1) ? blen + $urandom_range(1, 3) :
                                                            blen - $urandom_range(1, 3);
      push_be(blen, 8, file_q);
      foreach (body[i]) file_q.insert(file_q.size(), body[i]);
   endtask

   // a well-formed file: blocks, then an end on a boundary or inside a marker
   task send_file();
      int len, k;
      send_gaps = $urandom_range(0, 2) != 0;
      recv_stalls = $urandom_range(0, 2) != 0;
      file_q.delete();
      repeat ($urandom_range(1, 3)) add_block(F_NONE);
      len = sb.marker_len();
      if (len > 1 && $urandom_range(0, 3) == 0) begin
         k = $urandom_range(1, len - 1);
         for (int i = 0; i < k; i++)
            file_q.insert(file_q.size(),
                          $urandom_range(0, 1) ? sb.pattern[8 * (len - 1 - i) +: 8] :
                          8'($urandom_range(0, 255)));
      end
      foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
   endtask

   initial begin
      fault_kind fk;
      int ph, p;
      logic [63:0] pat;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: a short marker cut off, then a well-formed file on reset settings
      if (sb.marker_len() > 1) begin
         send_byte(8'h23, 1'b0);
         send_byte(8'hff, 1'b1);
      end
      send_file();

      ph = 0;
      while (bytes_sent < ITEM_TARGET) begin
         drain();
         // marker length: zero (acts as one), above range, full, one, then random
         case (ph)
            0: begin pat = '1; write_csr(CSR_MAGIC_LENGTH, 0); end
            1: begin pat = {$urandom, $urandom}; write_csr(CSR_MAGIC_LENGTH, 15); end
            2: begin pat = '0; write_csr(CSR_MAGIC_LENGTH, 8); end
            3: begin pat = {$urandom, $urandom}; write_csr(CSR_MAGIC_LENGTH, 1); end
            default: begin
               pat = {$urandom, $urandom};
               write_csr(CSR_MAGIC_LENGTH, {$urandom, $urandom});
            end
         endcase
         write_csr(CSR_MAGIC_PATTERN, pat);
         write_csr(CSR_VERSION, ph == 0 ? 32'd0 : ph == 1 ? 32'hffff_ffff : $urandom);
         repeat (3) if (bytes_sent < ITEM_TARGET) send_file();
         ph++;
      end

      // the run closes on a block that latches an error
      send_gaps = 1'b1;
      recv_stalls = 1'b1;
      fk = fault_kind'($urandom_range(F_MAGIC, F_TRUNC));
      file_q.delete();
      add_block(fk == F_TRUNC ? F_NONE : fk);
      if (fk == F_TRUNC) begin
         p = $urandom_range(sb.marker_len() - 1, file_q.size() - 2);
         for (int i = 0; i <= p; i++) send_byte(file_q[i], i == p);
      end else begin
         foreach (file_q[i]) send_byte(file_q[i], i == file_q.size() - 1);
      end
      // ignored once the error has stuck
      repeat (30) send_byte($urandom_range(0, 255), $urandom_range(0, 1));

      drain();
      repeat (20) @(posedge clock);
      if (sb.fails == 0 && sb.pending_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/lbsp_pkg.sv
hw/rtl/lbsp_front.sv
hw/rtl/lbsp_back.sv
hw/rtl/log_block_stream_parser_top.sv
hw/rtl/lbsp_checker.sv
bench/tb.sv
